[src/rebq_pkg.sv]
// Shared types, constants and helper functions for the rotary encoder and button qualifier.
`default_nettype none

package rebq_pkg;

    localparam int TIME_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        CFG_STEPS    = 3'd0,
        CFG_DEBOUNCE = 3'd1,
        CFG_GUARD    = 3'd2,
        CFG_MENU     = 3'd3,
        CFG_POWER    = 3'd4
    } cfg_index_t;

    localparam logic [3:0]       STEPS_RESET    = 4'd4;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_W-1:0] GUARD_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] MENU_RESET     = 16'd1200;
    localparam logic [CFG_W-1:0] POWER_RESET    = 16'd3500;

    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic                 enc_edge;
        logic signed [1:0]    direction;
        logic [TIME_BITS-1:0] since_edge;
    } enc_status_t;

    typedef struct packed {
        logic click;
        logic click_near_rotation;
        logic menu_hold;
        logic power_hold;
        logic pressed;
    } btn_status_t;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        return (v == TIME_MAX) ? v : TIME_BITS'(v + 1'b1);
    endfunction

endpackage

`default_nettype wire

[src/rebq_encoder.sv]
// Quadrature decoder with detent accumulator and saturating edge timer.
`default_nettype none

module rebq_encoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [1:0]            ab,
    input  wire logic [3:0]            steps_per_detent,
    output rebq_pkg::enc_status_t      status
);
    import rebq_pkg::*;

    logic [1:0]           prev_ab_reg, prev_ab_next;
    logic signed [4:0]    accum_reg, accum_next;
    logic [TIME_BITS-1:0] since_edge_reg, since_edge_next;

    logic signed [5:0]    sum;
    logic signed [5:0]    steps;
    logic [3:0]           steps_eff;

    always_comb begin
        steps_eff = (steps_per_detent == 4'd0) ? 4'd1 : steps_per_detent;
        steps     = $signed({2'b00, steps_eff});
        sum       = 6'(accum_reg) + 6'(QUAD_TABLE[{prev_ab_reg, ab}]);

        status.enc_edge  = (ab != prev_ab_reg);
        status.direction = 2'sd0;
        accum_next       = sum[4:0];
        if (sum >= steps) begin
            accum_next       = 5'sd0;
            status.direction = 2'sd1;
        end else if (sum <= -steps) begin
            accum_next       = 5'sd0;
            status.direction = -2'sd1;
        end

        since_edge_next   = status.enc_edge ? '0 : sat_inc(since_edge_reg);
        status.since_edge = since_edge_next;
        prev_ab_next      = ab;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ab_reg    <= 2'b00;
            accum_reg      <= 5'sd0;
            since_edge_reg <= TIME_MAX;
        end else if (step) begin
            prev_ab_reg    <= prev_ab_next;
            accum_reg      <= accum_next;
            since_edge_reg <= since_edge_next;
        end
    end

endmodule

`default_nettype wire

[src/rebq_button.sv]
// Button debouncer with click, rotation guard and hold event detection.
`default_nettype none

module rebq_button (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step,
    input  wire logic                     button_raw,
    input  wire logic [rebq_pkg::TIME_BITS-1:0] since_edge,
    input  wire logic [rebq_pkg::CFG_W-1:0]     debounce_ticks,
    input  wire logic [rebq_pkg::CFG_W-1:0]     rotation_guard_ticks,
    input  wire logic [rebq_pkg::CFG_W-1:0]     menu_hold_ticks,
    input  wire logic [rebq_pkg::CFG_W-1:0]     power_hold_ticks,
    output rebq_pkg::btn_status_t         status
);
    import rebq_pkg::*;

    logic                 last_raw_reg, last_raw_next;
    logic [TIME_BITS-1:0] since_raw_reg, since_raw_next;
    logic                 stable_reg, stable_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic                 menu_done_reg, menu_done_next;
    logic                 power_done_reg, power_done_next;

    logic accept;
    logic menu_done_base;
    logic power_done_base;

    always_comb begin
        last_raw_next  = button_raw;
        since_raw_next = (button_raw != last_raw_reg) ? '0 : sat_inc(since_raw_reg);
        accept         = (CMP_W'(since_raw_next) > CMP_W'(debounce_ticks)) &&
                         (button_raw != stable_reg);
        stable_next    = accept ? button_raw : stable_reg;

        status.pressed = accept && !button_raw;
        status.click   = accept && button_raw && !menu_done_reg && !power_done_reg;
        status.click_near_rotation = status.click &&
                                     (CMP_W'(since_edge) < CMP_W'(rotation_guard_ticks));

        if (status.pressed) begin
            press_next      = '0;
            menu_done_base  = 1'b0;
            power_done_base = 1'b0;
        end else begin
            press_next      = stable_next ? press_reg : sat_inc(press_reg);
            menu_done_base  = menu_done_reg;
            power_done_base = power_done_reg;
        end

        status.menu_hold  = !stable_next && !menu_done_base &&
                            (CMP_W'(press_next) >= CMP_W'(menu_hold_ticks));
        status.power_hold = !stable_next && !power_done_base &&
                            (CMP_W'(press_next) >= CMP_W'(power_hold_ticks));
        menu_done_next    = menu_done_base || status.menu_hold;
        power_done_next   = power_done_base || status.power_hold;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg   <= 1'b1;
            since_raw_reg  <= '0;
            stable_reg     <= 1'b1;
            press_reg      <= '0;
            menu_done_reg  <= 1'b0;
            power_done_reg <= 1'b0;
        end else if (step) begin
            last_raw_reg   <= last_raw_next;
            since_raw_reg  <= since_raw_next;
            stable_reg     <= stable_next;
            press_reg      <= press_next;
            menu_done_reg  <= menu_done_next;
            power_done_reg <= power_done_next;
        end
    end

endmodule

`default_nettype wire

[src/rotary_encoder_and_button_qualifier_unit.sv]
// Top level of the rotary encoder and button qualifier with stream ports and config registers.
// Each input word is one sampled tick of encoder A/B and the active-low button; each one
// yields exactly one result word. The input word is captured in an input register, the
// encoder and button state advance as it moves into the result register, so when the output
// side is not stalled a new word is taken every cycle and a result becomes valid at the
// clock edge after the one that accepts its input. The encoder accumulator and the debounce
// and hold counters update their state as each word advances into the result register.
// Configuration writes take effect at once.
`default_nettype none

module rotary_encoder_and_button_qualifier_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // enc_a, enc_b, button_raw, zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // direction[1:0], click, click_near_rotation,
                                        // menu_hold, power_hold, user_activity, zero fill
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import rebq_pkg::*;

    logic [3:0]       steps_reg;
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] guard_reg;
    logic [CFG_W-1:0] menu_reg;
    logic [CFG_W-1:0] power_reg;

    logic       in_valid_reg;
    logic [2:0] in_data_reg;
    logic       out_valid_reg;
    logic [6:0] out_data_reg, out_data_next;

    logic        out_ready;
    logic        advance;
    enc_status_t enc_status;
    btn_status_t btn_status;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg    <= STEPS_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            guard_reg    <= GUARD_RESET;
            menu_reg     <= MENU_RESET;
            power_reg    <= POWER_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STEPS:    steps_reg    <= cfg_wdata[3:0];
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                CFG_GUARD:    guard_reg    <= cfg_wdata;
                CFG_MENU:     menu_reg     <= cfg_wdata;
                CFG_POWER:    power_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rebq_encoder u_encoder (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (advance),
        .ab               ({in_data_reg[0], in_data_reg[1]}),
        .steps_per_detent (steps_reg),
        .status           (enc_status)
    );

    rebq_button u_button (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step                 (advance),
        .button_raw           (in_data_reg[2]),
        .since_edge           (enc_status.since_edge),
        .debounce_ticks       (debounce_reg),
        .rotation_guard_ticks (guard_reg),
        .menu_hold_ticks      (menu_reg),
        .power_hold_ticks     (power_reg),
        .status               (btn_status)
    );

    always_comb begin
        out_data_next = {enc_status.enc_edge || btn_status.pressed || btn_status.click,
                         btn_status.power_hold,
                         btn_status.menu_hold,
                         btn_status.click_near_rotation,
                         btn_status.click,
                         enc_status.direction};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[2:0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
